// ===== rtl/x86alu_pkg.sv =====
package x86alu_pkg;

	localparam int unsigned DATA_W  = 64;
	localparam int unsigned HALF_W  = 32;
	localparam int unsigned FLAGS_W = 32;

	typedef logic [2:0]         alu_op_t;
	typedef logic [DATA_W-1:0]  data_t;
	typedef logic [FLAGS_W-1:0] flags_t;

	localparam alu_op_t OP_ADD = 3'd0;
	localparam alu_op_t OP_OR  = 3'd1;
	localparam alu_op_t OP_ADC = 3'd2;
	localparam alu_op_t OP_SBB = 3'd3;
	localparam alu_op_t OP_AND = 3'd4;
	localparam alu_op_t OP_SUB = 3'd5;
	localparam alu_op_t OP_XOR = 3'd6;
	localparam alu_op_t OP_CMP = 3'd7;

	// Flag bit positions
	localparam int unsigned CF_BIT = 0;
	localparam int unsigned AF_BIT = 4;
	localparam int unsigned ZF_BIT = 6;
	localparam int unsigned SF_BIT = 7;
	localparam int unsigned OF_BIT = 11;
	localparam int unsigned PB_LSB = 24;

	// Bits of the incoming flags word that survive an update
	localparam flags_t KEEP_WITH_CF = 32'h00ff_f72f;
	localparam flags_t KEEP_NO_CF   = 32'h00ff_f72e;

	localparam data_t MASK_NARROW = {{(DATA_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};

endpackage

// ===== rtl/x86_alu_with_flags.sv =====
// Channel   Direction  Handshake        Payload
// command   in         start / busy     op, wide, operand_x, operand_y, flags_in,
//                                       write_back, keep_carry
// result    out        done (strobe)    result, flags_out, write_enable, unsupported
//
// One transaction per cycle; busy is held low, so start is accepted at every edge.
// The datapath is an operand register, then the adder/logic path (one
// 65-bit add) feeding the result register.
// done pulses for exactly one cycle per transaction; the receiver cannot stall.
// arst_n clears the valid bits of both stages; payload registers are not reset.
module x86_alu_with_flags (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  x86alu_pkg::alu_op_t        op,
	input  logic                       wide,
	input  x86alu_pkg::data_t          operand_x,
	input  x86alu_pkg::data_t          operand_y,
	input  x86alu_pkg::flags_t         flags_in,
	input  logic                       write_back,
	input  logic                       keep_carry,
	output logic                       done,
	output x86alu_pkg::data_t          result,
	output x86alu_pkg::flags_t         flags_out,
	output logic                       write_enable,
	output logic                       unsupported
);

	logic                   valid_s1;
	x86alu_pkg::alu_op_t    op_s1;
	logic                   wide_s1;
	x86alu_pkg::data_t      x_s1;
	x86alu_pkg::data_t      y_s1;
	x86alu_pkg::flags_t     flags_s1;
	logic                   wb_s1;
	logic                   keep_s1;

	logic                   valid_s2;
	x86alu_pkg::data_t      result_s2;
	x86alu_pkg::flags_t     flags_s2;
	logic                   we_s2;
	logic                   unsup_s2;

	x86alu_pkg::data_t      mask;
	x86alu_pkg::data_t      xm;
	x86alu_pkg::data_t      ym;
	logic                   is_sub;
	logic [x86alu_pkg::DATA_W:0] sum;
	x86alu_pkg::data_t      z_raw;
	x86alu_pkg::data_t      z;
	x86alu_pkg::data_t      ov_vec;
	logic                   is_arith;
	logic                   is_unsup;
	logic                   cf;
	logic                   af;
	logic                   of;
	logic                   sf;
	x86alu_pkg::flags_t     f_new;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_s1    <= op;
			wide_s1  <= wide;
			x_s1     <= operand_x;
			y_s1     <= operand_y;
			flags_s1 <= flags_in;
			wb_s1    <= write_back;
			keep_s1  <= keep_carry;
		end
	end

	assign mask   = wide_s1 ? '1 : x86alu_pkg::MASK_NARROW;
	assign xm     = x_s1 & mask;
	assign ym     = y_s1 & mask;
	assign is_sub = (op_s1 == x86alu_pkg::OP_SUB) || (op_s1 == x86alu_pkg::OP_CMP);

	// x + y, or x + ~y + 1; bit 64 is the borrow for subtract
	assign sum = {1'b0, xm} + (is_sub ? ~{1'b0, ym} : {1'b0, ym})
		+ {{x86alu_pkg::DATA_W{1'b0}}, is_sub};

	always_comb begin
		z_raw    = '0;
		is_arith = 1'b0;
		is_unsup = 1'b0;
		unique case (op_s1)
			x86alu_pkg::OP_ADD: begin
				z_raw    = sum[x86alu_pkg::DATA_W-1:0];
				is_arith = 1'b1;
			end
			x86alu_pkg::OP_OR:  z_raw = xm | ym;
			x86alu_pkg::OP_AND: z_raw = xm & ym;
			x86alu_pkg::OP_XOR: z_raw = xm ^ ym;
			x86alu_pkg::OP_SUB, x86alu_pkg::OP_CMP: begin
				z_raw    = sum[x86alu_pkg::DATA_W-1:0];
				is_arith = 1'b1;
			end
			x86alu_pkg::OP_ADC, x86alu_pkg::OP_SBB: is_unsup = 1'b1;
			default: is_unsup = 1'b1;
		endcase
	end

	assign z = z_raw & mask;

	// Narrow add carries out of bit 32; the borrow of a subtract always lands in bit 64
	assign cf = (is_sub || wide_s1) ? sum[x86alu_pkg::DATA_W] : sum[x86alu_pkg::HALF_W];
	assign af = xm[4] ^ ym[4] ^ z[4];
	assign ov_vec = is_sub ? ((xm ^ ym) & (z ^ xm)) : ((z ^ xm) & (z ^ ym));
	assign of = wide_s1 ? ov_vec[x86alu_pkg::DATA_W-1] : ov_vec[x86alu_pkg::HALF_W-1];
	assign sf = wide_s1 ? z[x86alu_pkg::DATA_W-1] : z[x86alu_pkg::HALF_W-1];

	always_comb begin
		f_new = flags_s1 & (keep_s1 ? x86alu_pkg::KEEP_WITH_CF : x86alu_pkg::KEEP_NO_CF);
		f_new[x86alu_pkg::ZF_BIT] = (z == '0);
		f_new[x86alu_pkg::SF_BIT] = sf;
		if (is_arith) begin
			if (!keep_s1) begin
				f_new[x86alu_pkg::CF_BIT] = cf;
			end
			f_new[x86alu_pkg::AF_BIT] = af;
			f_new[x86alu_pkg::OF_BIT] = of;
		end
		f_new[x86alu_pkg::PB_LSB +: 8] = z[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= is_unsup ? '0 : z;
			flags_s2  <= is_unsup ? flags_s1 : f_new;
			we_s2     <= wb_s1 && !is_unsup;
			unsup_s2  <= is_unsup;
		end
	end

	assign done         = valid_s2;
	assign result       = result_s2;
	assign flags_out    = flags_s2;
	assign write_enable = we_s2;
	assign unsupported  = unsup_s2;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##1 done)
		else $error("accepted transaction did not complete two cycles later");

	a_unsup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && unsupported |-> result == '0 && !write_enable)
		else $error("unsupported op produced a result or write enable");

	a_parity_byte: assert property (@(posedge clk) disable iff (!arst_n)
		done && !unsupported |-> flags_out[x86alu_pkg::PB_LSB +: 8] == result[7:0])
		else $error("parity byte does not match result low byte");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && !unsupported |-> flags_out[x86alu_pkg::ZF_BIT] == (result == '0))
		else $error("zero flag disagrees with result");

	a_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		start && !wide |=> ##1 (result[x86alu_pkg::DATA_W-1:x86alu_pkg::HALF_W] == '0))
		else $error("narrow operation left upper result bits set");

endmodule
